>>> rtl/rpfa_pkg.sv
// rpfa_pkg: shared types, command and status codes for the page frame allocator.
// No dependencies; imported by rpfa_ctrl, rpfa_dp, the top level and the testbench.
package rpfa_pkg;

    // Free-bit summary geometry: one row holds the in-use bits of 64 frames.
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    // Request command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_RETAIN  = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    // Response status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OOM     = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_UNALLOC = 3'd3;
    localparam logic [2:0] ST_SAT     = 3'd4;

    // Configuration register indexes (paddr[2])
    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_COMMIT,
        S_EVAL,
        S_RESP
    } fsm_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic idle;
        logic clear_step;
        logic accept;
        logic read;
        logic scan;
        logic commit;
        logic eval;
        logic respond;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_alloc;
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } dp_status_t;

    // Index of the single set bit of a one-hot word.
    function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (v[i])
            begin
                r = r | BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/rpfa_ram.sv
// rpfa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rpfa_ctrl.sv
// rpfa_ctrl: sequencing state machine of the page frame allocator.
// Depends on rpfa_pkg (state enum, command and status structs).
module rpfa_ctrl import rpfa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd
);

    fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = stat.is_alloc ? S_SCAN : S_EVAL;
            end
            S_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    state_next = S_COMMIT;
                end
                else if (stat.scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_COMMIT: state_next = S_RESP;
            S_EVAL:   state_next = S_RESP;
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_CLEAR:  cmd.clear_step = 1'b1;
            S_IDLE:
            begin
                cmd.idle   = 1'b1;
                cmd.accept = req_valid;
            end
            S_READ:   cmd.read    = 1'b1;
            S_SCAN:   cmd.scan    = 1'b1;
            S_COMMIT: cmd.commit  = 1'b1;
            S_EVAL:   cmd.eval    = 1'b1;
            S_RESP:   cmd.respond = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

>>> rtl/rpfa_dp.sv
// rpfa_dp: datapath - count RAM, free-bit summary RAM, used counter, result register.
// Depends on rpfa_pkg and rpfa_ram.
module rpfa_dp import rpfa_pkg::*; #(
    parameter int FRAMES     = 4096,
    parameter int COUNT_BITS = 8,
    localparam int IDX_W  = $clog2(FRAMES),
    localparam int CFG_W  = $clog2(FRAMES + 1),
    localparam int ROWS   = (FRAMES + WORD_BITS - 1) / WORD_BITS,
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            stat,
    input  logic [1:0]            req_command,
    input  logic [IDX_W-1:0]      req_frame_index,
    input  logic [CFG_W-1:0]      first_free_frame,
    input  logic [CFG_W-1:0]      frame_limit,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output logic [2:0]            rsp_status,
    output logic [IDX_W-1:0]      rsp_frame,
    output logic [COUNT_BITS-1:0] rsp_count,
    output logic [CFG_W-1:0]      rsp_free
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CFG_W-1:0]      FRAMES_C  = CFG_W'(FRAMES);

    // Registers
    logic [1:0]            cmd_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [ROW_AW-1:0]     scan_row_reg, scan_row_next;
    logic [ROW_AW-1:0]     clr_row_reg, clr_row_next;
    logic [CFG_W-1:0]      used_reg, used_next;
    logic [2:0]            res_status_reg, res_status_next;
    logic [IDX_W-1:0]      res_frame_reg, res_frame_next;
    logic [COUNT_BITS-1:0] res_count_reg, res_count_next;
    logic [WORD_BITS-1:0]  hit_word_reg, hit_word_next;
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            out_status_reg;
    logic [IDX_W-1:0]      out_frame_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [CFG_W-1:0]      out_free_reg;

    // Range
    logic [CFG_W-1:0]       lim_eff, lim_m1, span, free_now;
    logic                   empty;
    logic [CFG_W+BIT_W-1:0] first_ext, lim_ext;
    logic [ROW_AW-1:0]      first_row, last_row;
    logic [BIT_W-1:0]       first_bit, last_bit;

    assign lim_eff   = (frame_limit > FRAMES_C) ? FRAMES_C : frame_limit;
    assign lim_m1    = lim_eff - 1'b1;
    assign empty     = first_free_frame >= lim_eff;
    assign first_ext = {{BIT_W{1'b0}}, first_free_frame};
    assign lim_ext   = {{BIT_W{1'b0}}, lim_m1};
    assign first_row = first_ext[BIT_W +: ROW_AW];
    assign first_bit = first_ext[BIT_W-1:0];
    assign last_row  = lim_ext[BIT_W +: ROW_AW];
    assign last_bit  = lim_ext[BIT_W-1:0];
    assign span      = empty ? '0 : lim_eff - first_free_frame;
    assign free_now  = (used_reg >= span) ? '0 : span - used_reg;

    // Request frame split into summary row and bit
    logic [IDX_W+BIT_W-1:0] idx_ext;
    logic [ROW_AW-1:0]      idx_row;
    logic [BIT_W-1:0]       idx_bit;

    assign idx_ext = {{BIT_W{1'b0}}, idx_reg};
    assign idx_row = idx_ext[BIT_W +: ROW_AW];
    assign idx_bit = idx_ext[BIT_W-1:0];

    // RAMs
    logic                  bm_we;
    logic [ROW_AW-1:0]     bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0]  bm_wdata, bm_rdata;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

    rpfa_ram #(.WIDTH(WORD_BITS), .DEPTH(ROWS)) u_summary (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    rpfa_ram #(.WIDTH(COUNT_BITS), .DEPTH(FRAMES)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (idx_reg),
        .rdata (cnt_rdata)
    );

    // While scanning, fetch the following row so one row is checked per cycle.
    assign bm_raddr = cmd.scan ? scan_row_reg + 1'b1 :
                      ((cmd_reg == CMD_ALLOC) ? scan_row_reg : idx_row);

    // Scan of one summary row
    logic [BIT_W-1:0]     lo_bit, hi_bit, hit_bit;
    logic [WORD_BITS-1:0] mask, cand, onehot;
    logic                 scan_hit, scan_done;

    assign lo_bit    = (scan_row_reg == first_row) ? first_bit : '0;
    assign hi_bit    = (scan_row_reg == last_row) ? last_bit : BIT_W'(WORD_BITS - 1);
    assign mask      = ({WORD_BITS{1'b1}} << lo_bit)
                     & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
    assign cand      = ~bm_rdata & mask;
    assign onehot    = cand & (~cand + 1'b1);
    assign hit_bit   = onehot_index(onehot);
    assign scan_hit  = !empty && (|cand);
    assign scan_done = empty || (scan_row_reg == last_row);

    // Release / retain / query evaluation
    logic                  bit_set, in_lim, in_range;
    logic [COUNT_BITS-1:0] cur;
    logic [2:0]            ev_status;
    logic [COUNT_BITS-1:0] ev_count, ev_data;
    logic                  ev_write, ev_free, ev_dec;

    assign bit_set  = bm_rdata[idx_bit];
    assign cur      = bit_set ? cnt_rdata : '0;
    assign in_lim   = CFG_W'(idx_reg) < lim_eff;
    assign in_range = in_lim && (CFG_W'(idx_reg) >= first_free_frame);

    always_comb
    begin
        ev_status = ST_OK;
        ev_count  = '0;
        ev_data   = cur;
        ev_write  = 1'b0;
        ev_free   = 1'b0;
        ev_dec    = 1'b0;
        case (cmd_reg) inside
            CMD_QUERY:
            begin
                if (!in_lim)
                begin
                    ev_status = ST_RANGE;
                end
                else
                begin
                    ev_count = cur;
                end
            end
            CMD_RELEASE, CMD_RETAIN:
            begin
                if (!in_range)
                begin
                    ev_status = ST_RANGE;
                end
                else if (!bit_set)
                begin
                    ev_status = ST_UNALLOC;
                end
                else if (cmd_reg == CMD_RELEASE)
                begin
                    ev_data  = cur - 1'b1;
                    ev_count = ev_data;
                    ev_write = 1'b1;
                    if (cur == COUNT_BITS'(1))
                    begin
                        ev_free = 1'b1;
                        ev_dec  = used_reg != '0;
                    end
                end
                else if (cur == COUNT_MAX)
                begin
                    ev_status = ST_SAT;
                    ev_count  = COUNT_MAX;
                end
                else
                begin
                    ev_data  = cur + 1'b1;
                    ev_count = ev_data;
                    ev_write = 1'b1;
                end
            end
            default:
            begin
                ev_status = ST_OK;
            end
        endcase
    end

    // RAM writes
    always_comb
    begin
        bm_we     = 1'b0;
        bm_waddr  = idx_row;
        bm_wdata  = bm_rdata & ~(WORD_BITS'(1) << idx_bit);
        cnt_we    = 1'b0;
        cnt_waddr = idx_reg;
        cnt_wdata = ev_data;
        if (cmd.clear_step)
        begin
            bm_we    = 1'b1;
            bm_waddr = clr_row_reg;
            bm_wdata = '0;
        end
        else if (cmd.commit)
        begin
            bm_we     = 1'b1;
            bm_waddr  = scan_row_reg;
            bm_wdata  = hit_word_reg;
            cnt_we    = 1'b1;
            cnt_waddr = res_frame_reg;
            cnt_wdata = COUNT_BITS'(1);
        end
        else if (cmd.eval)
        begin
            bm_we  = ev_free;
            cnt_we = ev_write;
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || !rsp_stall;

    // Next-state of the datapath registers
    always_comb
    begin
        scan_row_next   = scan_row_reg;
        clr_row_next    = clr_row_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_count_next  = res_count_reg;
        hit_word_next   = hit_word_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        if (cmd.clear_step)
        begin
            clr_row_next = clr_row_reg + 1'b1;
        end
        if (cmd.accept)
        begin
            scan_row_next = first_row;
        end
        if (cmd.scan)
        begin
            if (scan_hit)
            begin
                hit_word_next   = bm_rdata | onehot;
                res_frame_next  = IDX_W'({scan_row_reg, hit_bit});
                res_status_next = ST_OK;
                res_count_next  = COUNT_BITS'(1);
            end
            else if (scan_done)
            begin
                res_frame_next  = '0;
                res_status_next = ST_OOM;
                res_count_next  = '0;
            end
            else
            begin
                scan_row_next = scan_row_reg + 1'b1;
            end
        end
        if (cmd.commit)
        begin
            used_next = used_reg + 1'b1;
        end
        if (cmd.eval)
        begin
            res_status_next = ev_status;
            res_frame_next  = idx_reg;
            res_count_next  = ev_count;
            if (ev_dec)
            begin
                used_next = used_reg - 1'b1;
            end
        end
        if (cmd.respond && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_row_reg   <= clr_row_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg <= req_command;
            idx_reg <= req_frame_index;
        end
        scan_row_reg   <= scan_row_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_count_reg  <= res_count_next;
        hit_word_reg   <= hit_word_next;
        if (cmd.respond && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_frame_reg  <= res_frame_reg;
            out_count_reg  <= res_count_reg;
            out_free_reg   <= free_now;
        end
    end

    assign stat.clear_last = clr_row_reg == ROW_AW'(ROWS - 1);
    assign stat.is_alloc   = cmd_reg == CMD_ALLOC;
    assign stat.scan_hit   = scan_hit;
    assign stat.scan_done  = scan_done;
    assign stat.out_free   = out_free;

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_frame  = out_frame_reg;
    assign rsp_count  = out_count_reg;
    assign rsp_free   = out_free_reg;

endmodule

>>> rtl/refcounted_page_frame_allocator_unit.sv
// refcounted_page_frame_allocator_unit: top level - APB registers, controller, datapath.
// Depends on rpfa_pkg, rpfa_ctrl, rpfa_dp (and rpfa_ram through rpfa_dp).
//
//  channel   | signals                                        | direction
//  ----------+------------------------------------------------+----------
//  request   | req_valid, req_stall, command, frame_index     | in
//  response  | rsp_valid, rsp_stall, status, result_frame,    | out
//            | ref_count, free_frames                         |
//  config    | psel, penable, pwrite, paddr, pwdata, prdata,  | APB
//            | pready                                         |
//
// Release, retain, query: from acceptance to a loaded response the request goes through RAM read,
// evaluate/write-back and response. Alloc: RAM read, a scan of the 64-bit summary rows, one per
// cycle (1..FRAMES/64 rows), a commit on a hit, then the response; every request also passes idle.
// After reset the summary RAM is cleared one row a cycle, all ceil(FRAMES/64) rows
// (64 by default); req_stall stays high until then, APB writes are taken.
// The response sits in an output register; the next request is accepted while it is stalled.
module refcounted_page_frame_allocator_unit import rpfa_pkg::*; #(
    parameter int FRAMES     = 4096,
    parameter int COUNT_BITS = 8,
    localparam int IDX_W = $clog2(FRAMES),
    localparam int CFG_W = $clog2(FRAMES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [1:0]            command,
    input  logic [IDX_W-1:0]      frame_index,

    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [2:0]            status,
    output logic [IDX_W-1:0]      result_frame,
    output logic [COUNT_BITS-1:0] ref_count,
    output logic [CFG_W-1:0]      free_frames,

    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Configuration registers: first_free_frame at 0x0, frame_limit at 0x4.
    // Word-aligned decode: only paddr[2] selects the register.
    logic [CFG_W-1:0] first_reg, first_next;
    logic [CFG_W-1:0] limit_reg, limit_next;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        first_next = first_reg;
        limit_next = limit_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_FIRST: first_next = pwdata[CFG_W-1:0];
                REG_LIMIT: limit_next = pwdata[CFG_W-1:0];
                default:   first_next = first_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            limit_reg <= CFG_W'(FRAMES);
        end
        else
        begin
            first_reg <= first_next;
            limit_reg <= limit_next;
        end
    end

    // paddr[1:0] only carry byte offsets within the word
    always_comb
    begin
        unique case (paddr[2])
            REG_FIRST: prdata = 32'(first_reg);
            REG_LIMIT: prdata = 32'(limit_reg);
            default:   prdata = '0;
        endcase
    end

    // Controller and datapath
    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_stat;

    rpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (dp_stat),
        .cmd       (ctrl_cmd)
    );

    // Requests are taken only in the idle state.
    assign req_stall = !ctrl_cmd.idle;

    rpfa_dp #(
        .FRAMES     (FRAMES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (ctrl_cmd),
        .stat             (dp_stat),
        .req_command      (command),
        .req_frame_index  (frame_index),
        .first_free_frame (first_reg),
        .frame_limit      (limit_reg),
        .rsp_stall        (rsp_stall),
        .rsp_valid        (rsp_valid),
        .rsp_status       (status),
        .rsp_frame        (result_frame),
        .rsp_count        (ref_count),
        .rsp_free         (free_frames)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_page_frame_allocator_unit: a frame refcount
// ledger predicts every response, and plain tasks drive the request and APB ports.
// Depends on rpfa_pkg and the allocator RTL only.

import rpfa_pkg::*;

// One predicted response.
typedef struct {
    logic [2:0]  status;
    logic [11:0] frame;
    logic [7:0]  count;
    logic [12:0] free;
} frame_reply_t;

// Mirror of the allocator state plus the queue of responses still owed.
class frame_refcount_ledger;
    localparam int NUM_FRAMES = 4096;
    localparam int COUNT_MAX  = 255;

    bit [7:0]     frame_refs [NUM_FRAMES];
    int           frames_in_use;
    int           first_reg;
    int           limit_reg;
    int           last_grant;
    int           errors;
    frame_reply_t replies_due [$];

    function new();
        foreach (frame_refs[i])
        begin
            frame_refs[i] = '0;
        end
        frames_in_use = 0;
        first_reg     = 0;
        limit_reg     = NUM_FRAMES;
        last_grant    = 0;
        errors        = 0;
    endfunction

    function void write_reg(logic reg_sel, int value);
        if (reg_sel == REG_FIRST)
        begin
            first_reg = value & 'h1FFF;
        end
        else
        begin
            limit_reg = value & 'h1FFF;
        end
    endfunction

    // Limit above the frame count acts as the frame count.
    function int top_frame();
        return (limit_reg > NUM_FRAMES) ? NUM_FRAMES : limit_reg;
    endfunction

    function int free_now();
        int hi;
        int span;
        hi = top_frame();
        if (first_reg >= hi)
        begin
            return 0;
        end
        span = hi - first_reg;
        return (frames_in_use >= span) ? 0 : span - frames_in_use;
    endfunction

    function int pending();
        return replies_due.size();
    endfunction

    // Apply one accepted request and queue the response it must produce.
    function void note_request(logic [1:0] cmd, logic [11:0] idx);
        frame_reply_t r;
        int           hi;
        int           i;
        bit           found;
        hi       = top_frame();
        r.status = ST_OK;
        r.frame  = idx;
        r.count  = '0;
        if (cmd == CMD_ALLOC)
        begin
            r.frame = '0;
            found   = 1'b0;
            for (i = first_reg; i < hi && !found; i++)
            begin
                if (frame_refs[i] == 0)
                begin
                    frame_refs[i] = 8'd1;
                    frames_in_use++;
                    r.frame    = 12'(i);
                    r.count    = 8'd1;
                    last_grant = i;
                    found      = 1'b1;
                end
            end
            if (!found)
            begin
                r.status = ST_OOM;
            end
        end
        else if (cmd == CMD_QUERY)
        begin
            if (idx < hi)
            begin
                r.count = frame_refs[idx];
            end
            else
            begin
                r.status = ST_RANGE;
            end
        end
        else if (idx < first_reg || idx >= hi)
        begin
            r.status = ST_RANGE;
        end
        else if (frame_refs[idx] == 0)
        begin
            r.status = ST_UNALLOC;
        end
        else if (cmd == CMD_RELEASE)
        begin
            frame_refs[idx]--;
            if (frame_refs[idx] == 0 && frames_in_use > 0)
            begin
                frames_in_use--;
            end
            r.count = frame_refs[idx];
        end
        else
        begin
            if (frame_refs[idx] >= COUNT_MAX)
            begin
                r.status = ST_SAT;
            end
            else
            begin
                frame_refs[idx]++;
            end
            r.count = frame_refs[idx];
        end
        r.free = 13'(free_now());
        replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [12:0] expected, logic [12:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
            errors++;
        end
    endfunction

    function void check_reply(logic [2:0] st, logic [11:0] fr, logic [7:0] cnt,
                              logic [12:0] fre);
        frame_reply_t e;
        if (replies_due.size() == 0)
        begin
            $display("%0t: response with nothing outstanding: status %0d frame %0d count %0d",
                     $time, st, fr, cnt);
            errors++;
            return;
        end
        e = replies_due.pop_front();
        compare_field("status", 13'(e.status), 13'(st));
        compare_field("result_frame", 13'(e.frame), 13'(fr));
        compare_field("ref_count", 13'(e.count), 13'(cnt));
        compare_field("free_frames", e.free, fre);
    endfunction
endclass

module testbench;
    localparam int FRAMES     = 4096;
    localparam int COUNT_BITS = 8;
    localparam int IDX_W      = 12;
    localparam int CFG_W      = 13;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic [1:0]            command;
    logic [IDX_W-1:0]      frame_index;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic [2:0]            status;
    logic [IDX_W-1:0]      result_frame;
    logic [COUNT_BITS-1:0] ref_count;
    logic [CFG_W-1:0]      free_frames;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    frame_refcount_ledger ledger;

    // Sender burst bookkeeping and the range currently programmed.
    int burst_left = 0;
    int cfg_first  = 0;
    int cfg_limit  = FRAMES;

    // Receiver stall pattern state.
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    bit hold_val   = 1'b0;

    refcounted_page_frame_allocator_unit #(
        .FRAMES     (FRAMES),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .frame_index  (frame_index),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .result_frame (result_frame),
        .ref_count    (ref_count),
        .free_frames  (free_frames),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: now and then picks a mode - never stall, random 40% stalls,
    // or alternating stretches of stall and release.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 40);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_val  = !hold_val;
                    hold_left = hold_val ? $urandom_range(1, 20) : $urandom_range(1, 10);
                end
                hold_left--;
                rsp_stall <= hold_val;
            end
        endcase
    end

    // Response monitor: inputs are driven with NBAs, so at the edge we see
    // the values the DUT sampled.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            ledger.check_reply(status, result_frame, ref_count, free_frames);
        end
    end

    // One request. Bursts of random length, random gaps between them; a gap
    // of zero chains bursts back to back. Valid stays up inside a burst.
    task automatic send(logic [1:0] cmd, logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_valid   <= 1'b1;
        command     <= cmd;
        frame_index <= idx;
        do @(posedge clk); while (req_stall);
        ledger.note_request(cmd, idx);
        burst_left--;
    endtask

    // Stop requesting, let every owed response arrive, then hold off so
    // the datapath is back in idle.
    task automatic drain();
        req_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup, access, then a return to idle with psel low so
    // back-to-back writes never assign psel twice in one step.
    task automatic cfg_write(logic reg_sel, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        ledger.write_reg(reg_sel, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_range(int lo, int hi);
        drain();
        cfg_write(REG_FIRST, lo);
        cfg_write(REG_LIMIT, hi);
        cfg_first = lo & 'h1FFF;
        cfg_limit = hi & 'h1FFF;
    endtask

    // Mostly in or just around the allocatable range, where live frames sit;
    // some fully random indexes as noise.
    function automatic logic [IDX_W-1:0] pick_frame();
        int lo;
        int hi;
        int v;
        lo = cfg_first;
        hi = (cfg_limit > FRAMES) ? FRAMES : cfg_limit;
        if ($urandom_range(0, 99) < 15 || lo >= hi)
        begin
            return IDX_W'($urandom);
        end
        v = lo - 2 + $urandom_range(0, hi - lo + 3);
        if (v < 0)
        begin
            v = 0;
        end
        if (v > FRAMES - 1)
        begin
            v = FRAMES - 1;
        end
        return IDX_W'(v);
    endfunction

    function automatic logic [1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            return CMD_ALLOC;
        end
        else if (r < 60)
        begin
            return CMD_RELEASE;
        end
        else if (r < 80)
        begin
            return CMD_RETAIN;
        end
        return CMD_QUERY;
    endfunction

    initial
    begin
        int lo;
        int grant;
        ledger = new();

        rst_n       <= 1'b0;
        req_valid   <= 1'b0;
        command     <= CMD_ALLOC;
        frame_index <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset range, empty store. The summary clear after reset
        // holds req_stall high; send just waits on it.
        send(CMD_QUERY, 12'd0);
        send(CMD_RELEASE, 12'd0);       // release of a free frame
        send(CMD_RETAIN, 12'd4095);     // retain of a free frame
        send(CMD_ALLOC, 12'd4095);      // index ignored, lowest free is 0
        send(CMD_ALLOC, 12'd0);
        send(CMD_RETAIN, 12'd1);
        send(CMD_RELEASE, 12'd1);
        send(CMD_RELEASE, 12'd1);       // count hits zero, frame freed
        send(CMD_RELEASE, 12'd1);
        send(CMD_QUERY, 12'd1);

        // Top two frames only: fill, then out of memory; below-first indexes
        set_range(4094, 4096);
        send(CMD_ALLOC, 12'd0);
        send(CMD_ALLOC, 12'd0);
        send(CMD_ALLOC, 12'd0);
        send(CMD_RELEASE, 12'd5);
        send(CMD_RETAIN, 12'd0);
        send(CMD_QUERY, 12'd0);         // query only checks the limit

        // Empty range
        set_range(0, 0);
        send(CMD_ALLOC, 12'd0);
        send(CMD_QUERY, 12'd0);

        // All-ones registers: limit clamps to the frame count, first is past it
        set_range(8191, 8191);
        send(CMD_ALLOC, 12'd0);
        send(CMD_QUERY, 12'd4095);
        send(CMD_RETAIN, 12'd4095);

        // First above limit
        set_range(100, 50);
        send(CMD_RELEASE, 12'd60);

        // Two-frame range with more frames in use than it holds: free saturates
        set_range(0, 2);
        send(CMD_QUERY, 12'd2);
        send(CMD_RELEASE, 12'd0);
        send(CMD_ALLOC, 12'd0);

        // Hammer one frame up to the count ceiling and past it, then back down
        set_range(0, FRAMES);
        send(CMD_ALLOC, 12'd0);
        grant = ledger.last_grant;
        repeat (258) send(CMD_RETAIN, IDX_W'(grant));
        repeat (4) send(CMD_RELEASE, IDX_W'(grant));

        // Random phases, each under its own range
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_range(0, FRAMES);
                1:
                begin
                    lo = $urandom_range(0, 4032);
                    set_range(lo, lo + $urandom_range(1, 48));
                end
                2: set_range($urandom_range(4000, 4095), $urandom_range(4097, 8191));
                3:
                begin
                    lo = $urandom_range(0, 100);
                    set_range(lo, lo + $urandom_range(1, 16));
                end
                default: set_range($urandom_range(0, 8), $urandom_range(0, 40));
            endcase
            repeat (100) send(pick_command(), pick_frame());
        end

        drain();
        repeat (8) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: ends the run as a failure, far beyond the slowest legal run
    initial
    begin
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/rpfa_pkg.sv
rtl/rpfa_ram.sv
rtl/rpfa_ctrl.sv
rtl/rpfa_dp.sv
rtl/refcounted_page_frame_allocator_unit.sv
verif/testbench.sv
